@@ rtl/four_wheel_slew_limited_speed_command_unit_defines.svh @@
// Assertion macros for the four-wheel speed command unit.
`ifndef FOUR_WHEEL_SLEW_LIMITED_SPEED_COMMAND_UNIT_DEFINES_SVH
`define FOUR_WHEEL_SLEW_LIMITED_SPEED_COMMAND_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define FWSL_ASSERT_HOLDS(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FWSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fwsl_pkg.sv @@
// Shared types, constants and codes of the four-wheel speed command unit.
`default_nettype none

package fwsl_pkg;

	localparam int RAW_WHEELS      = 4;
	localparam int WHEELS_DEF      = 4;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam int RAW_W   = 8;
	localparam int SP_W    = 17;   // scaled setpoint, signed Q9.8
	localparam int CMD_W   = 16;   // command, signed Q8.8
	localparam int FRAC_W  = 8;
	localparam int ACC_W   = 19;   // room for prev +/- step and s - prev
	localparam int BSUM_W  = 10;
	localparam int SIL_W   = 10;
	localparam int DATA_W  = RAW_WHEELS * RAW_W;

	localparam int RAW_OFFSET = 101;
	localparam int CMD_OFFSET = 91;

	// sp*1536/7 as a multiply by ceil(2^20/7); exact for |sp| <= 232
	localparam int SCALE_SHIFT = 20;
	localparam int SCALE_RECIP = 149797;
	localparam int SCALE_MUL   = 1536 * SCALE_RECIP;
	localparam int MUL_W       = 28;
	localparam int PROD_W      = RAW_W + MUL_W;

	// output lane of each wheel in the result word
	localparam int OUT_POS [RAW_WHEELS] = '{0, 1, 3, 2};

	localparam logic OP_SETPOINT = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MAX   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_MIN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLEW_THR  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT   = 3'd4;

	typedef struct packed {
		logic [6:0]        out_max;
		logic signed [7:0] out_min;
		logic [13:0]       max_step;
		logic [6:0]        slew_thr;
		logic [9:0]        timeout;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		out_max:  7'd75,
		out_min:  -8'sd75,
		max_step: 14'd3048,
		slew_thr: 7'd40,
		timeout:  10'd30
	};

	typedef struct packed {
		logic                             op;
		logic [RAW_WHEELS-1:0][SP_W-1:0]  sp;
	} qent_t;

endpackage

`default_nettype wire

@@ rtl/four_wheel_slew_limited_speed_command_unit.sv @@
// Top level of the four-wheel slew-limited speed command unit.
//
// Input stream s_*: tuser carries op (0 setpoint message, 1 control tick),
// tdata the four setpoint bytes. Output stream m_*: one result per tick,
// tdata the four command bytes, tuser the timeout flag; setpoint messages
// give no result. cfg_we/cfg_idx/cfg_data write one register per cycle;
// write only while the unit is idle.
// A tick accepted into the queue moves into the result register once it is
// at the queue head and the result register is free.
// Throughput: one request per cycle while the queue has room; the per-wheel
// slew/clamp path is combinational and the state update is registered.
// Reset clears setpoints, previous commands, the silence counter and the
// queue, and loads the register defaults.
// When a result is pending and m_tready is low the result register holds; a
// setpoint message at the queue head still drains, ticks wait in the queue,
// and s_tready drops once it is full.
`default_nettype none
`include "four_wheel_slew_limited_speed_command_unit_defines.svh"

module four_wheel_slew_limited_speed_command_unit #(
	parameter int WHEELS      = fwsl_pkg::WHEELS_DEF,
	parameter int QUEUE_DEPTH = fwsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// fields from bit 0: front_left_raw, front_right_raw, rear_right_raw, rear_left_raw
	input  logic [fwsl_pkg::DATA_W-1:0]         s_tdata,
	// fields from bit 0: op
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// fields from bit 0: front_left_cmd, front_right_cmd, rear_left_cmd, rear_right_cmd
	output logic [fwsl_pkg::DATA_W-1:0]         m_tdata,
	// fields from bit 0: timed_out
	output logic [0:0]                          m_tuser,
	input  logic                                cfg_we,
	input  logic [fwsl_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [fwsl_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import fwsl_pkg::*;

	cfg_t   cfg_q;
	logic   q_ready;
	logic   q_push;
	qent_t  q_in;
	logic   q_valid;
	logic   q_pop;
	qent_t  q_entry;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_OUT_MAX:  cfg_q.out_max  <= cfg_data[6:0];
				CFG_OUT_MIN:  cfg_q.out_min  <= $signed(cfg_data[7:0]);
				CFG_MAX_STEP: cfg_q.max_step <= cfg_data[13:0];
				CFG_SLEW_THR: cfg_q.slew_thr <= cfg_data[6:0];
				CFG_TIMEOUT:  cfg_q.timeout  <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	fwsl_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_ready  (q_ready),
		.q_push   (q_push),
		.q_entry  (q_in)
	);

	fwsl_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.in_ready  (q_ready),
		.entry_in  (q_in),
		.pop       (q_pop),
		.out_valid (q_valid),
		.entry_out (q_entry)
	);

	fwsl_back #(
		.WHEELS (WHEELS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_valid  (q_valid),
		.q_entry  (q_entry),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// a tick may only leave the queue when the result register is free
	`FWSL_ASSERT_HOLDS(a_no_result_overwrite, q_pop && q_entry.op == OP_TICK, !m_tvalid || m_tready, "tick popped over a pending result")
	`FWSL_ASSERT_NEXT(a_tick_gives_result, q_pop && q_entry.op == OP_TICK, m_tvalid, "tick popped without a result")
	`FWSL_ASSERT_HOLDS(a_backpressure_only_when_full, !s_tready, q_valid, "input stalled with an empty queue")

endmodule

`default_nettype wire

@@ rtl/fwsl_front.sv @@
// Front end: takes requests, decodes the kind and scales setpoint bytes.
`default_nettype none

module fwsl_front (
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// fields from bit 0: front_left_raw, front_right_raw, rear_right_raw, rear_left_raw
	input  logic [fwsl_pkg::DATA_W-1:0]          s_tdata,
	// fields from bit 0: op
	input  logic [0:0]                           s_tuser,
	input  logic                                 q_ready,
	output logic                                 q_push,
	output fwsl_pkg::qent_t                      q_entry
);
	import fwsl_pkg::*;

	logic signed [RAW_W:0]  sp_raw [RAW_WHEELS];
	logic [RAW_W-1:0]       mag    [RAW_WHEELS];
	logic [PROD_W-1:0]      prod   [RAW_WHEELS];
	logic [CMD_W-1:0]       qmag   [RAW_WHEELS];

	assign s_tready = q_ready;
	assign q_push   = s_tvalid && q_ready;

	always_comb begin
		q_entry.op = s_tuser[0];
		for (int w = 0; w < RAW_WHEELS; w++) begin
			sp_raw[w] = $signed({1'b0, s_tdata[w*RAW_W +: RAW_W]})
				- $signed((RAW_W+1)'(RAW_OFFSET));
			mag[w]    = sp_raw[w][RAW_W] ? RAW_W'(-sp_raw[w]) : sp_raw[w][RAW_W-1:0];
			prod[w]   = PROD_W'(mag[w]) * PROD_W'(SCALE_MUL);
			qmag[w]   = prod[w][SCALE_SHIFT +: CMD_W];
			q_entry.sp[w] = sp_raw[w][RAW_W] ? SP_W'(-$signed({1'b0, qmag[w]}))
				: {1'b0, qmag[w]};
		end
	end

endmodule

`default_nettype wire

@@ rtl/fwsl_queue.sv @@
// Short request queue between the front end and the command datapath.
`default_nettype none

module fwsl_queue #(
	parameter int DEPTH = fwsl_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             in_ready,
	input  fwsl_pkg::qent_t  entry_in,
	input  logic             pop,
	output logic             out_valid,
	output fwsl_pkg::qent_t  entry_out
);
	import fwsl_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	qent_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign in_ready  = count_q != CNT_W'(DEPTH);
	assign out_valid = count_q != '0;
	assign entry_out = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/fwsl_back.sv @@
// Back end: setpoint state, timeout, slew limit, clamp and result register.
`default_nettype none

module fwsl_back #(
	parameter int WHEELS = fwsl_pkg::WHEELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fwsl_pkg::cfg_t                cfg,
	input  logic                          q_valid,
	input  fwsl_pkg::qent_t               q_entry,
	output logic                          q_pop,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// fields from bit 0: front_left_cmd, front_right_cmd, rear_left_cmd, rear_right_cmd
	output logic [fwsl_pkg::DATA_W-1:0]   m_tdata,
	// fields from bit 0: timed_out
	output logic [0:0]                    m_tuser
);
	import fwsl_pkg::*;

	logic signed [SP_W-1:0]    sp_q     [WHEELS];
	logic signed [CMD_W-1:0]   prev_q   [WHEELS];
	logic [SIL_W-1:0]          silence_q;
	logic                      m_tvalid_q;
	logic [DATA_W-1:0]         m_tdata_q;
	logic                      m_tuser_q;

	logic                      is_tick;
	logic                      out_free;
	logic                      timed;
	logic signed [ACC_W-1:0]   hi;
	logic signed [ACC_W-1:0]   lo;
	logic signed [ACC_W-1:0]   thr;
	logic signed [ACC_W-1:0]   step;

	logic signed [SP_W-1:0]    sp_new   [WHEELS];
	logic signed [SP_W-1:0]    sp_eff   [WHEELS];
	logic signed [ACC_W-1:0]   s_w      [WHEELS];
	logic signed [ACC_W-1:0]   prev_w   [WHEELS];
	logic signed [ACC_W-1:0]   diff     [WHEELS];
	logic signed [ACC_W-1:0]   abs_s    [WHEELS];
	logic signed [ACC_W-1:0]   abs_d    [WHEELS];
	logic signed [ACC_W-1:0]   lim      [WHEELS];
	logic signed [ACC_W-1:0]   clp      [WHEELS];
	logic signed [CMD_W-1:0]   cmd      [WHEELS];
	logic signed [BSUM_W-1:0]  bsum     [WHEELS];
	logic [RAW_W-1:0]          cmd_byte [WHEELS];
	logic [RAW_W-1:0]          lane_byte [RAW_WHEELS];
	logic [DATA_W-1:0]         tdata_d;

	assign is_tick  = q_entry.op == OP_TICK;
	assign out_free = !m_tvalid_q || m_tready;
	assign q_pop    = q_valid && (!is_tick || out_free);
	assign timed    = silence_q >= cfg.timeout;

	assign hi   = $signed(ACC_W'({cfg.out_max, {FRAC_W{1'b0}}}));
	assign lo   = {{(ACC_W-CMD_W){cfg.out_min[7]}}, cfg.out_min, {FRAC_W{1'b0}}};
	assign thr  = $signed(ACC_W'({cfg.slew_thr, {FRAC_W{1'b0}}}));
	assign step = $signed(ACC_W'(cfg.max_step));

	// wheels past the fourth have no setpoint byte
	for (genvar w = 0; w < WHEELS; w++) begin : g_sp_new
		if (w < RAW_WHEELS) begin : g_raw
			assign sp_new[w] = $signed(q_entry.sp[w]);
		end else begin : g_none
			assign sp_new[w] = '0;
		end
	end

	always_comb begin
		for (int w = 0; w < WHEELS; w++) begin
			sp_eff[w] = timed ? '0 : sp_q[w];
			s_w[w]    = ACC_W'(sp_eff[w]);
			prev_w[w] = ACC_W'(prev_q[w]);
			diff[w]   = s_w[w] - prev_w[w];
			abs_s[w]  = s_w[w][ACC_W-1] ? -s_w[w] : s_w[w];
			abs_d[w]  = diff[w][ACC_W-1] ? -diff[w] : diff[w];
			if (abs_s[w] >= thr && abs_d[w] > step) begin
				lim[w] = (s_w[w] > prev_w[w]) ? prev_w[w] + step : prev_w[w] - step;
			end else begin
				lim[w] = s_w[w];
			end
			// if the bounds cross, values above the upper bound take it, all others the lower
			if (lim[w] > hi) begin
				clp[w] = hi;
			end else if (lim[w] < lo) begin
				clp[w] = lo;
			end else begin
				clp[w] = lim[w];
			end
			cmd[w]      = (sp_eff[w] == '0) ? '0 : clp[w][CMD_W-1:0];
			bsum[w]     = {{(BSUM_W-RAW_W){cmd[w][CMD_W-1]}}, cmd[w][CMD_W-1:FRAC_W]}
				+ $signed(BSUM_W'(CMD_OFFSET));
			cmd_byte[w] = bsum[w][BSUM_W-1] ? '0 : bsum[w][RAW_W-1:0];
		end
	end

	for (genvar k = 0; k < RAW_WHEELS; k++) begin : g_lane
		if (k < WHEELS) begin : g_used
			assign lane_byte[k] = cmd_byte[k];
		end else begin : g_idle
			assign lane_byte[k] = RAW_W'(CMD_OFFSET);
		end
		assign tdata_d[OUT_POS[k]*RAW_W +: RAW_W] = lane_byte[k];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int w = 0; w < WHEELS; w++) begin
				sp_q[w]   <= '0;
				prev_q[w] <= '0;
			end
			silence_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (q_pop && is_tick) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (q_pop) begin
				if (is_tick) begin
					for (int w = 0; w < WHEELS; w++) begin
						sp_q[w]   <= sp_eff[w];
						prev_q[w] <= cmd[w];
					end
					if (silence_q != '1) begin
						silence_q <= silence_q + 1'b1;
					end
				end else begin
					for (int w = 0; w < WHEELS; w++) begin
						sp_q[w] <= sp_new[w];
					end
					silence_q <= '0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop && is_tick) begin
			m_tdata_q <= tdata_d;
			m_tuser_q <= timed;
		end
	end

	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign m_tuser[0] = m_tuser_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the four-wheel slew-limited speed command unit.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import fwsl_pkg::*;

	localparam int SETTLE_CYCLES = 4;
	localparam int RANDOM_ITEMS  = 1100;
	localparam int CHUNK_ITEMS   = 120;
	localparam int SILENCE_MAX   = 1023;

	typedef struct {
		int out_max;
		int out_min;
		int max_step;
		int slew_thr;
		int timeout;
	} limits_t;

	typedef struct packed {
		logic       timed_out;
		logic [7:0] rear_right;
		logic [7:0] rear_left;
		logic [7:0] front_right;
		logic [7:0] front_left;
	} wheel_cmds_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	// from bit 0: front_left_raw, front_right_raw, rear_right_raw, rear_left_raw
	logic [DATA_W-1:0]     s_tdata = '0;
	// from bit 0: op
	logic [0:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	// from bit 0: front_left_cmd, front_right_cmd, rear_left_cmd, rear_right_cmd
	logic [DATA_W-1:0]     m_tdata;
	// from bit 0: timed_out
	logic [0:0]            m_tuser;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	four_wheel_slew_limited_speed_command_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the unit's registers and state
	limits_t     lim = '{75, -75, 3048, 40, 30};
	int          wheel_sp [4];
	int          prev_cmd [4];
	int          silence;
	wheel_cmds_t pending_cmds [$];
	wheel_cmds_t oldest_cmds;
	int          mismatches = 0;
	int          burst_left = 0;
	bit          steady_send = 1'b0;
	int          rx_hold = 0;
	int          rx_cycle = 0;

	function automatic int magnitude(int v);
		return v < 0 ? -v : v;
	endfunction

	// sp * 256 * 6 / 7, truncated toward zero
	function automatic int scale_setpoint(int sp);
		int q;
		q = (magnitude(sp) * 1536) / 7;
		return sp < 0 ? -q : q;
	endfunction

	function automatic logic [7:0] cmd_byte(int cmd);
		int b;
		b = (cmd >>> 8) + CMD_OFFSET;
		if (b < 0)
			b = 0;
		if (b > 255)
			b = 255;
		return b[7:0];
	endfunction

	function automatic void take_request(logic op, logic [DATA_W-1:0] raw);
		int          s;
		int          hi;
		int          lo;
		logic [7:0]  cmd [4];
		wheel_cmds_t r;
		if (op == OP_SETPOINT) begin
			for (int w = 0; w < 4; w++)
				wheel_sp[w] = int'(raw[8*w +: 8]) - RAW_OFFSET;
			silence = 0;
			return;
		end
		hi = lim.out_max * 256;
		lo = lim.out_min * 256;
		r.timed_out = silence >= lim.timeout;
		if (r.timed_out)
			for (int w = 0; w < 4; w++)
				wheel_sp[w] = 0;
		if (silence < SILENCE_MAX)
			silence++;
		for (int w = 0; w < 4; w++) begin
			s = scale_setpoint(wheel_sp[w]);
			if (magnitude(s) >= lim.slew_thr * 256 &&
					magnitude(s - prev_cmd[w]) > lim.max_step)
				s = (s > prev_cmd[w]) ? prev_cmd[w] + lim.max_step
					: prev_cmd[w] - lim.max_step;
			// if the bounds cross, values above the upper bound take it, all others the lower
			if (s > hi)
				s = hi;
			else if (s < lo)
				s = lo;
			if (wheel_sp[w] == 0)
				s = 0;
			prev_cmd[w] = s;
			cmd[w] = cmd_byte(s);
		end
		// wheel order is fl, fr, rr, rl
		r.front_left  = cmd[0];
		r.front_right = cmd[1];
		r.rear_right  = cmd[2];
		r.rear_left   = cmd[3];
		pending_cmds.push_back(r);
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_cmds.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h/%b", $time,
					m_tdata, m_tuser);
				mismatches++;
			end else begin
				oldest_cmds = pending_cmds.pop_front();
				check_field("front_left_cmd", oldest_cmds.front_left, m_tdata[7:0]);
				check_field("front_right_cmd", oldest_cmds.front_right, m_tdata[15:8]);
				check_field("rear_left_cmd", oldest_cmds.rear_left, m_tdata[23:16]);
				check_field("rear_right_cmd", oldest_cmds.rear_right, m_tdata[31:24]);
				check_field("timed_out", oldest_cmds.timed_out, m_tuser[0]);
			end
		end
	end

	// result side: long hold when asked, else one of four ready patterns picked by rx_cycle
	always @(negedge clk) begin
		rx_cycle++;
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold--;
		end else begin
			case ((rx_cycle / 250) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= (rx_cycle % 7) < 3;
				default: m_tready <= $urandom_range(0, 3) == 0;
			endcase
		end
	end

	// entered and left at a falling edge
	task automatic send_request(logic op, logic [DATA_W-1:0] raw);
		if (!steady_send && burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= raw;
		do
			@(posedge clk);
		while (!s_tready);
		take_request(op, raw);
		@(negedge clk);
	endtask

	task automatic wait_results();
		s_tvalid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		// a trailing setpoint request may still be in flight
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
	endtask

	task automatic apply_limits(limits_t l);
		write_reg(CFG_OUT_MAX, l.out_max);
		write_reg(CFG_OUT_MIN, l.out_min & 'hFF);
		write_reg(CFG_MAX_STEP, l.max_step);
		write_reg(CFG_SLEW_THR, l.slew_thr);
		write_reg(CFG_TIMEOUT, l.timeout);
		cfg_we <= 1'b0;
		lim = l;
		@(negedge clk);
	endtask

	function automatic logic [7:0] setpoint_byte();
		case ($urandom_range(0, 9))
			0: return 8'(RAW_OFFSET);
			1: return 8'd0;
			2: return 8'd255;
			3, 4: return 8'(RAW_OFFSET - 8 + $urandom_range(0, 16));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// reset registers: tick on zero state, full-scale slew and clamp, reversal
	task automatic test_default_limits();
		send_request(OP_TICK, $urandom);
		send_request(OP_SETPOINT, {8'd200, 8'd101, 8'd0, 8'd255});
		repeat (3) send_request(OP_TICK, $urandom);
		send_request(OP_SETPOINT, {8'd255, 8'd0, 8'd255, 8'd0});
		repeat (2) send_request(OP_TICK, $urandom);
		wait_results();
	endtask

	// widest and narrowest settings, timeout at 1 and 0, crossed clamp bounds
	task automatic test_register_extremes();
		apply_limits('{127, -128, 16383, 0, 1});
		send_request(OP_SETPOINT, {8'd100, 8'd102, 8'd255, 8'd0});
		repeat (3) send_request(OP_TICK, $urandom);
		wait_results();
		apply_limits('{0, 0, 0, 127, 0});
		send_request(OP_SETPOINT, {8'd0, 8'd255, 8'd150, 8'd60});
		repeat (2) send_request(OP_TICK, $urandom);
		wait_results();
		apply_limits('{5, 20, 16383, 0, 30});
		send_request(OP_SETPOINT, {8'd60, 8'd150, 8'd0, 8'd255});
		repeat (2) send_request(OP_TICK, $urandom);
		wait_results();
	endtask

	// result side held off while ticks keep coming, then drain fully
	task automatic test_backpressure();
		apply_limits('{75, -75, 3048, 40, 30});
		steady_send = 1'b1;
		rx_hold = 150;
		send_request(OP_SETPOINT, {setpoint_byte(), setpoint_byte(), setpoint_byte(),
			setpoint_byte()});
		repeat (16) send_request(OP_TICK, $urandom);
		steady_send = 1'b0;
		wait_results();
	endtask

	task automatic test_random_traffic();
		int      sent;
		int      chunk;
		int      ticks;
		limits_t l;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_results();
			l.out_max = $urandom_range(0, 127);
			if ($urandom_range(0, 4) == 0)
				l.out_min = int'($urandom_range(0, 255)) - 128;
			else
				l.out_min = -int'($urandom_range(0, 90));
			l.max_step = $urandom_range(0, 1) ? $urandom_range(0, 4000)
				: $urandom_range(0, 16383);
			l.slew_thr = $urandom_range(0, 127);
			case ($urandom_range(0, 9))
				0: l.timeout = 0;
				1, 2, 3, 4, 5: l.timeout = $urandom_range(1, 12);
				default: l.timeout = $urandom_range(13, 1023);
			endcase
			apply_limits(l);
			chunk = 0;
			while (chunk < CHUNK_ITEMS) begin
				if ($urandom_range(0, 99) < 85) begin
					ticks = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 40)
						: $urandom_range(1, 12);
					send_request(OP_SETPOINT, {setpoint_byte(), setpoint_byte(),
						setpoint_byte(), setpoint_byte()});
					repeat (ticks) send_request(OP_TICK, $urandom);
					chunk += ticks + 1;
				end else begin
					send_request(1'($urandom_range(0, 1)), $urandom);
					chunk++;
				end
			end
			sent += chunk;
		end
	endtask

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_default_limits();
		test_register_extremes();
		test_backpressure();
		test_random_traffic();
		wait_results();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

	initial begin
		#(3_000_000);
		$display("tb_top NOT OK");
		$finish;
	end

endmodule
